### hw/rtl/pstm_pkg.sv
// Shared types and constants for the speaker tone mixer.
`timescale 1ns / 1ps

package pstm_pkg;

	// Sample and phase widths
	localparam int SAMPLE_W = 16;
	localparam int BOUND_W  = 32;
	localparam int PHASE_W  = BOUND_W + 1;

	// Phase advance per frame: twice the timer input clock
	localparam logic [PHASE_W-1:0] PHASE_STEP = 33'd2386364;

	// High level of the square tone
	localparam int LEVEL_W = 15;
	localparam logic [LEVEL_W-1:0] TONE_HIGH = 15'd24575;

	// One remainder step per dividend bit
	localparam int REM_STEPS = PHASE_W;
	localparam int REM_CNT_W = $clog2(REM_STEPS + 1);

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_SPK_EN = 2'd0,
		CFG_STEREO = 2'd1,
		CFG_BOUND  = 2'd2
	} cfg_idx_t;

	// Sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_MOD
	} state_t;

	// Request into the remainder unit
	typedef struct packed {
		logic               start;
		logic [PHASE_W-1:0] dividend;
		logic [BOUND_W-1:0] divisor;
	} rem_req_t;

	// Status out of the remainder unit
	typedef struct packed {
		logic               busy;
		logic               done;
		logic [BOUND_W-1:0] remainder;
	} rem_sts_t;

endpackage

### hw/rtl/pstm_mixer.sv
// Mixes the square tone level into one stereo frame.
`timescale 1ns / 1ps

module pstm_mixer (
	input  logic                           enable,
	input  logic                           stereo,
	input  logic                           level_hi,
	input  logic [pstm_pkg::SAMPLE_W-1:0]  left_in,
	input  logic [pstm_pkg::SAMPLE_W-1:0]  right_in,
	output logic [pstm_pkg::SAMPLE_W-1:0]  left_out,
	output logic [pstm_pkg::SAMPLE_W-1:0]  right_out
);
	import pstm_pkg::*;

	logic [LEVEL_W-1:0]  level;
	logic [SAMPLE_W:0]   sum_l, sum_r;
	logic [SAMPLE_W:0]   adj_l, adj_r;

	assign level = level_hi ? TONE_HIGH : '0;

	// Signed sum, then halve toward zero: add one before the shift when negative
	assign sum_l = {left_in[SAMPLE_W-1], left_in}
		+ {{(SAMPLE_W + 1 - LEVEL_W){1'b0}}, level};
	assign sum_r = {right_in[SAMPLE_W-1], right_in}
		+ {{(SAMPLE_W + 1 - LEVEL_W){1'b0}}, level};
	assign adj_l = sum_l + {{SAMPLE_W{1'b0}}, sum_l[SAMPLE_W]};
	assign adj_r = sum_r + {{SAMPLE_W{1'b0}}, sum_r[SAMPLE_W]};

	// Channel select
	always_comb begin
		left_out  = left_in;
		right_out = right_in;
		if (enable) begin
			left_out = adj_l[SAMPLE_W:1];
			if (stereo) begin
				right_out = adj_r[SAMPLE_W:1];
			end
		end
	end

endmodule

### hw/rtl/pstm_rem_unit.sv
// Restoring remainder unit: one dividend bit per cycle through a shared subtractor.
`timescale 1ns / 1ps

module pstm_rem_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  pstm_pkg::rem_req_t req,
	output pstm_pkg::rem_sts_t sts
);
	import pstm_pkg::*;

	logic [REM_CNT_W-1:0] cnt_q;
	logic [PHASE_W-1:0]   dvd_q;
	logic [BOUND_W-1:0]   div_q;
	logic [BOUND_W-1:0]   rem_q;
	logic [PHASE_W-1:0]   trial;
	logic [PHASE_W-1:0]   diff;
	logic                 ge;
	logic [PHASE_W-1:0]   nxt;
	logic                 busy;

	// Shared subtract and compare
	assign trial = {rem_q, dvd_q[PHASE_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};
	assign nxt   = ge ? diff : trial;
	assign busy  = cnt_q != '0;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= REM_CNT_W'(REM_STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy) begin
			dvd_q <= {dvd_q[PHASE_W-2:0], 1'b0};
			rem_q <= nxt[BOUND_W-1:0];
		end
	end

	// Remainder stays below the divisor, so the top bit is always clear
	assign sts.busy      = busy;
	assign sts.done      = cnt_q == REM_CNT_W'(1);
	assign sts.remainder = nxt[BOUND_W-1:0];

endmodule

### hw/rtl/pc_speaker_tone_mixer.sv
// Top level: square-wave speaker tone mixed into a stereo sample stream.
// Usage:
//   Slave channel s_* takes one frame per transfer: left and right samples in
//   s_tdata, buffer end marker on s_tlast. Master channel m_* returns one
//   mixed frame per input frame in the same order, marker on m_tlast.
//   Registers are written through cfg_we/cfg_index/cfg_data while idle; any
//   write to a listed register clears the tone phase and level.
// Flow:
//   An accepted frame goes to the hold stage, then to the output register on
//   m_*. The hold stage keeps s_tready low until it drains, so a new frame is
//   not taken before the last one has left it. A frame whose phase passes the
//   bound keeps s_tready low for the 33 steps of the bit-serial remainder
//   unit that reduces the 33-bit phase by the bound; a frame whose phase
//   stays below it, or with the speaker off or a zero bound, skips that unit.
// Reset:
//   arst_n clears the sequencer, both output stages and the tone state;
//   speaker off, stereo on, bound zero.
// Stalls:
//   One result waits on m_*, one more in a hold stage; a third frame is
//   taken only after the hold stage drains into the output register.
`timescale 1ns / 1ps

module pc_speaker_tone_mixer (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// Input frames
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [15:0] left_in, [31:16] right_in
	input  logic        s_tlast,  // block_end_in
	// Output frames
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [15:0] left_out, [31:16] right_out
	output logic        m_tlast   // block_end_out
);
	import pstm_pkg::*;

	state_t              state_q, state_d;
	logic                spk_en_q, stereo_q;
	logic [BOUND_W-1:0]  bound_q;
	logic [PHASE_W-1:0]  phase_q;
	logic                level_q;
	logic                s_accept;
	logic                step_on;
	logic [PHASE_W-1:0]  phase_sum;
	logic                wrap;
	logic                cfg_hit;
	rem_req_t            rem_req;
	rem_sts_t            rem_sts;
	logic [SAMPLE_W-1:0] mix_l, mix_r;
	logic                hold_vld_q;
	logic [SAMPLE_W-1:0] hold_l_q, hold_r_q;
	logic                hold_last_q;
	logic                out_vld_q;
	logic [SAMPLE_W-1:0] out_l_q, out_r_q;
	logic                out_last_q;
	logic                move;

	assign s_tready = (state_q == ST_IDLE) && !hold_vld_q;
	assign s_accept = s_tvalid && s_tready;

	// Phase advance and wrap detect
	assign step_on   = spk_en_q && (bound_q != '0);
	assign phase_sum = phase_q + PHASE_STEP;
	assign wrap      = phase_sum >= {1'b0, bound_q};

	// Remainder request
	assign rem_req.start    = s_accept && step_on && wrap;
	assign rem_req.dividend = phase_sum;
	assign rem_req.divisor  = bound_q;

	pstm_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.sts    (rem_sts)
	);

	pstm_mixer u_mix (
		.enable    (spk_en_q),
		.stereo    (stereo_q),
		.level_hi  (level_q),
		.left_in   (s_tdata[SAMPLE_W-1:0]),
		.right_in  (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
		.left_out  (mix_l),
		.right_out (mix_r)
	);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (rem_req.start) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (rem_sts.done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Register index decode
	always_comb begin
		cfg_hit = 1'b0;
		unique case (cfg_index)
			CFG_SPK_EN, CFG_STEREO, CFG_BOUND: cfg_hit = cfg_we;
			default: cfg_hit = 1'b0;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spk_en_q <= 1'b0;
			stereo_q <= 1'b1;
			bound_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SPK_EN: spk_en_q <= cfg_data[0];
				CFG_STEREO: stereo_q <= cfg_data[0];
				CFG_BOUND:  bound_q  <= cfg_data[BOUND_W-1:0];
				default: ;
			endcase
		end
	end

	// Tone phase and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			level_q <= 1'b0;
		end else if (cfg_hit) begin
			phase_q <= '0;
			level_q <= 1'b0;
		end else if (s_accept && step_on) begin
			if (wrap) begin
				level_q <= !level_q;
			end else begin
				phase_q <= phase_sum;
			end
		end else if (state_q == ST_MOD && rem_sts.done) begin
			phase_q <= {1'b0, rem_sts.remainder};
		end
	end

	// Hold stage and output register
	assign move = hold_vld_q && (!out_vld_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (s_accept) begin
				hold_vld_q <= 1'b1;
			end else if (move) begin
				hold_vld_q <= 1'b0;
			end
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			hold_l_q    <= mix_l;
			hold_r_q    <= mix_r;
			hold_last_q <= s_tlast;
		end
		if (move) begin
			out_l_q    <= hold_l_q;
			out_r_q    <= hold_r_q;
			out_last_q <= hold_last_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_r_q, out_l_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	// Idle phase always sits below a nonzero bound
	a_phase_below_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && bound_q != '0) |-> (phase_q < {1'b0, bound_q}))
		else $error("phase count not below bound while idle");

	// The remainder unit only runs during the reduction state
	a_rem_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		rem_sts.busy |-> (state_q == ST_MOD))
		else $error("remainder unit busy outside reduction state");

	// A new frame never lands on an occupied hold stage
	a_hold_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |-> !hold_vld_q)
		else $error("hold stage overwritten");
`endif

endmodule

### verif/tb_top.sv
// Self-checking testbench for the speaker tone mixer: directed and random frames.
`timescale 1ns / 1ps

module tb_top;
	import pstm_pkg::*;

	// Index past the register list; a write there must change nothing
	localparam logic [1:0] CFG_NONE = 2'd3;
	// Idle cycles before a register write: covers a full remainder pass
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       last;
	} frame_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = CFG_SPK_EN;
	logic [31:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;  // [15:0] left_in, [31:16] right_in
	logic        s_tlast   = 1'b0;  // block_end_in
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;  // [15:0] left_out, [31:16] right_out
	logic        m_tlast;  // block_end_out

	// Mirror of the tone state and registers
	logic               spk_on     = 1'b0;
	logic               stereo_on  = 1'b1;
	logic [BOUND_W-1:0] wrap_bound = '0;
	logic [PHASE_W-1:0] phase_cnt  = '0;
	logic [LEVEL_W-1:0] tone_lvl   = '0;

	frame_t mixed_q[$];
	int     mismatch_cnt = 0;
	int     tx_idle_pct  = 21;
	int     rx_idle_pct  = 45;

	pc_speaker_tone_mixer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// (sample + level) / 2, truncated toward zero
	function automatic logic signed [SAMPLE_W-1:0] mix_sample(input logic signed [SAMPLE_W-1:0] s);
		int sum;
		sum = s;
		sum = sum + tone_lvl;
		return SAMPLE_W'(sum / 2);
	endfunction

	// Expected output frame; with the speaker on and a nonzero bound, advances phase and level
	function automatic frame_t mix_frame(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r, input logic last);
		frame_t f;
		f.left  = l;
		f.right = r;
		f.last  = last;
		if (spk_on) begin
			f.left = mix_sample(l);
			if (stereo_on) begin
				f.right = mix_sample(r);
			end
			// zero bound freezes the tone
			if (wrap_bound != '0) begin
				phase_cnt = phase_cnt + PHASE_STEP;
				if (phase_cnt >= {1'b0, wrap_bound}) begin
					phase_cnt = phase_cnt % {1'b0, wrap_bound};
					tone_lvl  = TONE_HIGH - tone_lvl;
				end
			end
		end
		return f;
	endfunction

	// Register write as seen by the tone state
	function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] data);
		case (idx)
			CFG_SPK_EN: spk_on = data[0];
			CFG_STEREO: stereo_on = data[0];
			CFG_BOUND: wrap_bound = data;
			default: return;
		endcase
		phase_cnt = '0;
		tone_lvl  = '0;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return -16'sd1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Receiver: random backpressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Output check against the oldest expected frame
	always @(posedge clk) begin : check_out
		frame_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (mixed_q.size() == 0) begin
				$error("output frame with nothing expected: %h", m_tdata);
				mismatch_cnt++;
			end else begin
				want = mixed_q.pop_front();
				if (m_tdata[15:0] !== want.left) begin
					$error("left_out: expected %0d, got %0d", want.left,
						$signed(m_tdata[15:0]));
					mismatch_cnt++;
				end
				if (m_tdata[31:16] !== want.right) begin
					$error("right_out: expected %0d, got %0d", want.right,
						$signed(m_tdata[31:16]));
					mismatch_cnt++;
				end
				if (m_tlast !== want.last) begin
					$error("block_end_out: expected %0d, got %0d", want.last, m_tlast);
					mismatch_cnt++;
				end
			end
		end
	end

	// One input transfer; each cycle before it idles with the sender's idle odds
	task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
			input logic signed [SAMPLE_W-1:0] r, input logic last);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r, l};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		mixed_q.push_back(mix_frame(l, r, last));
	endtask

	// Stop sending and wait until the block is quiet
	task automatic drain_tone_path();
		s_tvalid <= 1'b0;
		while (mixed_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, data);
		@(posedge clk);
	endtask

	// Reset state: speaker off, samples pass unchanged
	task automatic test_reset_passthrough();
		send_frame(16'sh8000, 16'sh7FFF, 1'b1);
		send_frame(16'sh7FFF, 16'sh8000, 1'b0);
		send_frame(16'sd0, -16'sd1, 1'b1);
		send_frame(-16'sd3, 16'sd5, 1'b0);
	endtask

	// Level held at zero: halving only, rounding toward zero
	task automatic test_zero_bound();
		drain_tone_path();
		write_reg(CFG_SPK_EN, 32'h0000_0001);
		write_reg(CFG_BOUND, 32'h0);
		send_frame(-16'sd1, -16'sd3, 1'b0);
		send_frame(16'sh7FFF, 16'sh8000, 1'b1);
		send_frame(16'sd1, 16'sd3, 1'b0);
		send_frame(-16'sd32767, 16'sd0, 1'b1);
	endtask

	// Bound of one: the level flips on every frame
	task automatic test_toggle_each_frame();
		drain_tone_path();
		write_reg(CFG_BOUND, 32'h1);
		send_frame(16'sh7FFF, 16'sh8000, 1'b0);
		send_frame(16'sh8000, 16'sh7FFF, 1'b1);
		send_frame(-16'sd1, 16'sd1, 1'b0);
		send_frame(16'sh8000, -16'sd24576, 1'b1);
	endtask

	// Mono: right sample passes through
	task automatic test_mono();
		drain_tone_path();
		write_reg(CFG_STEREO, 32'hFFFF_FFFE);
		send_frame(16'sh7FFF, 16'sh8000, 1'b1);
		send_frame(16'sh8000, 16'sh7FFF, 1'b0);
		send_frame(-16'sd24576, -16'sd1, 1'b1);
	endtask

	// Phase lands exactly on the bound
	task automatic test_exact_step_bound();
		drain_tone_path();
		write_reg(CFG_STEREO, 32'h0000_0001);
		write_reg(CFG_BOUND, 32'(PHASE_STEP));
		send_frame(16'sd100, -16'sd100, 1'b0);
		send_frame(-16'sd24575, 16'sd1, 1'b0);
		send_frame(16'sd7, -16'sd7, 1'b1);
	endtask

	// Largest bound: counter climbs without wrapping
	task automatic test_max_bound();
		drain_tone_path();
		write_reg(CFG_BOUND, 32'hFFFF_FFFF);
		send_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
		send_frame(16'sh8000, 16'sh8000, 1'b1);
	endtask

	// Unlisted index keeps the tone; disabling clears it and passes samples through
	task automatic test_unlisted_index();
		drain_tone_path();
		write_reg(CFG_BOUND, 32'h1);
		send_frame(16'sd11, -16'sd11, 1'b0);
		drain_tone_path();
		write_reg(CFG_NONE, 32'hFFFF_FFFF);
		send_frame(16'sd11, -16'sd11, 1'b1);
		drain_tone_path();
		write_reg(CFG_SPK_EN, 32'hA5A5_A5A4);
		send_frame(-16'sd9, 16'sd9, 1'b0);
	endtask

	// Random settings and frames under one idle pattern
	task automatic test_random_mode(input int tx_pct, input int rx_pct, input int frames);
		int sent;
		int seg_len;
		int i;
		bit held;
		logic [31:0] bnd;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		held = 1'b0;
		while (sent < frames) begin
			drain_tone_path();
			case ($urandom_range(0, 9))
				0: bnd = 32'h0;
				1: bnd = 32'h1;
				2: bnd = 32'(PHASE_STEP);
				3: bnd = 32'hFFFF_FFFF;
				4: bnd = $urandom;
				default: bnd = $urandom_range(2, 12_000_000);
			endcase
			write_reg(CFG_STEREO, ($urandom & 32'hFFFF_FFFE) | $urandom_range(0, 1));
			write_reg(CFG_BOUND, bnd);
			write_reg(CFG_SPK_EN, ($urandom & 32'hFFFF_FFFE) | ($urandom_range(0, 9) != 0));
			if ($urandom_range(0, 3) == 0) begin
				write_reg(CFG_NONE, $urandom);
			end
			seg_len = $urandom_range(10, 40);
			for (i = 0; i < seg_len; i++) begin
				// once per pattern, hold off until everything is back
				if (!held && i == seg_len / 2) begin
					drain_tone_path();
					held = 1'b1;
				end
				send_frame(rand_sample(), rand_sample(), $urandom_range(0, 7) == 0);
			end
			sent += seg_len;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_passthrough();
		test_zero_bound();
		test_toggle_each_frame();
		test_mono();
		test_exact_step_bound();
		test_max_bound();
		test_unlisted_index();
		test_random_mode(21, 45, 270);
		test_random_mode(45, 21, 270);
		test_random_mode(0, 0, 260);
		drain_tone_path();
		if (mismatch_cnt == 0 && mixed_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
